// ===== hw/rtl/i2c_master_bit_engine_assert.svh =====
// Assertion macros for the I2C master bit engine RTL.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/i2cm_pkg.sv =====
// Package: opcodes, phase counts and shared types of the I2C master bit engine.
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int BITS_PER_BYTE = 8;
    // write/read: two phases per bit plus a closing SCL-low phase
    localparam logic [4:0] LAST_PHASE = 5'(2 * BITS_PER_BYTE);
    localparam logic [15:0] TPP_RESET = 16'd50;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_GACK  = 3'd6
    } t_opcode;

    // Bus drive levels and the data kept alongside them.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] shift;
        logic       ack;
    } t_line;

    function automatic logic [4:0] phase_total(input t_opcode cmd);
        logic [4:0] n;
        unique case (cmd)
            OP_START: n = 5'd3;
            OP_STOP:  n = 5'd2;
            OP_WRITE: n = LAST_PHASE + 5'd1;
            OP_READ:  n = LAST_PHASE + 5'd1;
            OP_SACK:  n = 5'd4;
            OP_GACK:  n = 5'd3;
            default:  n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/i2cm_if.sv =====
// Request and result channel interfaces of the I2C master bit engine.
`timescale 1ns / 1ps

interface i2cm_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_sample;

    modport source (output valid, opcode, write_data, ack_level, sda_sample, input ready);
    modport sink   (input valid, opcode, write_data, ack_level, sda_sample, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_line;
    logic       sda_line;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_seen;
    logic       rejected;

    modport source (output valid, scl_line, sda_line, busy_res, done_res, read_data,
                    ack_seen, rejected, input ready);
    modport sink   (input valid, scl_line, sda_line, busy_res, done_res, read_data,
                    ack_seen, rejected, output ready);
endinterface

// ===== hw/rtl/i2cm_phase.sv =====
// Phase entry decode: drive levels and shifting on the first tick of a phase.
`timescale 1ns / 1ps

module i2cm_phase (
    input  logic             i_en,
    input  i2cm_pkg::t_opcode i_cmd,
    input  logic [4:0]       i_phase,
    input  logic             i_ack_drive,
    input  logic             i_sda_in,
    input  i2cm_pkg::t_line  i_cur,
    output i2cm_pkg::t_line  o_nxt
);

    logic last;
    logic odd;

    assign last = (i_phase == i2cm_pkg::LAST_PHASE);
    assign odd  = i_phase[0];

    always_comb begin
        o_nxt = i_cur;
        if (i_en) begin
            unique case (i_cmd)
                i2cm_pkg::OP_START: begin
                    if (i_phase == 5'd0) begin
                        o_nxt.sda = 1'b1;
                        o_nxt.scl = 1'b1;
                    end else if (i_phase == 5'd1) begin
                        o_nxt.sda = 1'b0;
                    end else begin
                        o_nxt.scl = 1'b0;
                    end
                end
                i2cm_pkg::OP_STOP: begin
                    if (i_phase == 5'd0) begin
                        o_nxt.sda = 1'b0;
                        o_nxt.scl = 1'b1;
                    end else begin
                        o_nxt.sda = 1'b1;
                    end
                end
                i2cm_pkg::OP_WRITE: begin
                    if (last) begin
                        o_nxt.scl = 1'b0;
                    end else if (!odd) begin
                        o_nxt.scl = 1'b0;
                        o_nxt.sda = i_cur.shift[7];
                    end else begin
                        o_nxt.scl   = 1'b1;
                        o_nxt.shift = {i_cur.shift[6:0], 1'b0};
                    end
                end
                i2cm_pkg::OP_READ: begin
                    if (last || !odd) begin
                        o_nxt.scl = 1'b0;
                    end else begin
                        o_nxt.scl   = 1'b1;
                        o_nxt.shift = {i_cur.shift[6:0], i_sda_in};
                    end
                end
                i2cm_pkg::OP_SACK: begin
                    if (i_phase == 5'd0) begin
                        o_nxt.scl = 1'b0;
                    end else if (i_phase == 5'd1) begin
                        o_nxt.sda = i_ack_drive;
                    end else if (i_phase == 5'd2) begin
                        o_nxt.scl = 1'b1;
                    end else begin
                        o_nxt.scl = 1'b0;
                    end
                end
                i2cm_pkg::OP_GACK: begin
                    if (i_phase == 5'd1) begin
                        o_nxt.scl = 1'b1;
                        o_nxt.ack = i_sda_in;
                    end else begin
                        o_nxt.scl = 1'b0;
                    end
                end
                default: begin
                    o_nxt = i_cur;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: tick handling, state and result register.
//
//  channel   dir   handshake     payload
//  i_req     in    valid/ready   opcode, write_data, ack_level, sda_sample
//  o_res     out   valid/ready   scl_line, sda_line, busy_res, done_res,
//                                read_data, ack_seen, rejected
//  cfg       in    i_cfg_we      i_cfg_wdata = ticks_per_phase
//
// One request is one bus tick and yields exactly one result.
// The request is decoded and the state updated in the accept cycle; the
// result sits in the output register the cycle after.
// Throughput is one request per clock; the output register decouples the two
// sides, i_req.ready drops only while a held result is not taken.
// Reset (synchronous, active low) idles the engine with both lines released
// and ticks_per_phase at 50. A phase length of 0 is treated as 1.
`timescale 1ns / 1ps

`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    i2cm_req_if.sink          i_req,
    i2cm_res_if.source        o_res
);

    // configuration
    logic [15:0] r_tpp;

    // engine state
    i2cm_pkg::t_opcode r_cmd;
    logic [4:0]        r_phase;
    logic [15:0]       r_tick;
    i2cm_pkg::t_line   r_line;
    logic [7:0]        r_read_latch;
    logic              r_ack_drive;

    // result register
    logic       r_out_valid;
    logic       r_scl, r_sda, r_busy, r_done, r_ack_seen, r_rej;
    logic [7:0] r_rdata;

    // per-tick decode
    logic              accept;
    logic              is_cmd;
    logic              start;
    logic              rej_c;
    i2cm_pkg::t_opcode cmd_eff;
    logic [4:0]        phase_eff;
    logic [15:0]       tick_eff;
    logic              ack_drive_eff;
    i2cm_pkg::t_line   line_eff;
    i2cm_pkg::t_line   line_ph;
    logic              active;
    logic [15:0]       len;
    logic [16:0]       tick_inc;
    logic              phase_end;
    logic [4:0]        phase_inc;
    logic              finish;

    i2cm_pkg::t_opcode n_cmd;
    logic [4:0]        n_phase;
    logic [15:0]       n_tick;
    logic [7:0]        n_read_latch;

    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    // opcode 7 means nothing: never started, never rejected
    assign is_cmd = (i_req.opcode >= i2cm_pkg::OP_START) && (i_req.opcode <= i2cm_pkg::OP_GACK);
    assign start  = is_cmd && (r_cmd == i2cm_pkg::OP_NONE);
    assign rej_c  = is_cmd && (r_cmd != i2cm_pkg::OP_NONE);

    // a new command starts its first phase on the tick that carries it
    always_comb begin
        cmd_eff       = r_cmd;
        phase_eff     = r_phase;
        tick_eff      = r_tick;
        ack_drive_eff = r_ack_drive;
        line_eff      = r_line;
        if (start) begin
            cmd_eff   = i2cm_pkg::t_opcode'(i_req.opcode);
            phase_eff = 5'd0;
            tick_eff  = 16'd0;
            case (cmd_eff)
                i2cm_pkg::OP_WRITE: line_eff.shift = i_req.write_data;
                i2cm_pkg::OP_READ: begin
                    line_eff.shift = 8'd0;
                    line_eff.sda   = 1'b1;
                end
                i2cm_pkg::OP_GACK:  line_eff.sda = 1'b1;
                i2cm_pkg::OP_SACK:  ack_drive_eff = i_req.ack_level;
                default:            line_eff = r_line;
            endcase
        end
    end

    assign active = (cmd_eff != i2cm_pkg::OP_NONE);

    i2cm_phase u_phase (
        .i_en        (active && (tick_eff == 16'd0)),
        .i_cmd       (cmd_eff),
        .i_phase     (phase_eff),
        .i_ack_drive (ack_drive_eff),
        .i_sda_in    (i_req.sda_sample),
        .i_cur       (line_eff),
        .o_nxt       (line_ph)
    );

    assign len       = (r_tpp == 16'd0) ? 16'd1 : r_tpp;
    assign tick_inc  = {1'b0, tick_eff} + 17'd1;
    assign phase_end = active && (tick_inc >= {1'b0, len});
    assign phase_inc = phase_eff + 5'd1;
    assign finish    = phase_end && (phase_inc >= i2cm_pkg::phase_total(cmd_eff));

    always_comb begin
        n_cmd        = cmd_eff;
        n_phase      = phase_eff;
        n_tick       = active ? tick_inc[15:0] : tick_eff;
        n_read_latch = r_read_latch;
        if (phase_end) begin
            n_tick  = 16'd0;
            n_phase = phase_inc;
            if (finish) begin
                n_cmd   = i2cm_pkg::OP_NONE;
                n_phase = 5'd0;
                if (cmd_eff == i2cm_pkg::OP_READ) begin
                    n_read_latch = line_ph.shift;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpp <= i2cm_pkg::TPP_RESET;
        end else if (i_cfg_we) begin
            r_tpp <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= i2cm_pkg::OP_NONE;
            r_phase      <= 5'd0;
            r_tick       <= 16'd0;
            r_line       <= '{scl: 1'b1, sda: 1'b1, shift: 8'd0, ack: 1'b1};
            r_read_latch <= 8'd0;
            r_ack_drive  <= 1'b1;
        end else if (accept) begin
            r_cmd        <= n_cmd;
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_line       <= line_ph;
            r_read_latch <= n_read_latch;
            r_ack_drive  <= ack_drive_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, loaded with each request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scl      <= line_ph.scl;
            r_sda      <= line_ph.sda;
            r_busy     <= (n_cmd != i2cm_pkg::OP_NONE);
            r_done     <= finish;
            r_rdata    <= n_read_latch;
            r_ack_seen <= line_ph.ack;
            r_rej      <= rej_c;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_line  = r_scl;
    assign o_res.sda_line  = r_sda;
    assign o_res.busy_res  = r_busy;
    assign o_res.done_res  = r_done;
    assign o_res.read_data = r_rdata;
    assign o_res.ack_seen  = r_ack_seen;
    assign o_res.rejected  = r_rej;

    // a finished command leaves the engine idle
    `I2CM_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_done, !r_busy, "done with busy")

    // phase counter stays inside the running command's sequence
    `I2CM_ASSERT_NOW(a_phase_range, i_clk, i_rst_n, r_cmd != i2cm_pkg::OP_NONE, r_phase < i2cm_pkg::phase_total(r_cmd), "phase out of range")

    // a command taken while idle is either running or reported done next
    `I2CM_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, accept && start, (r_cmd != i2cm_pkg::OP_NONE) || r_done, "started command lost")

endmodule
